// ----- rtl/box2d_pair_collision_defines.svh -----
// assertion macros for the box pair collision block
// used by modules that carry concurrent checks, expects clk and rst_n in scope
`ifndef BOX2D_PAIR_COLLISION_DEFINES_SVH
`define BOX2D_PAIR_COLLISION_DEFINES_SVH

// condition must hold whenever ante is seen
`define B2PC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after ante
`define B2PC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/b2pc_pkg.sv -----
// types, constants and helpers for the box pair collision block
// no dependencies
`default_nettype none

package b2pc_pkg;

    localparam logic signed [15:0] OneQ14 = 16'sd16384;
    localparam int unsigned        RndQ14 = 8192;

    typedef struct packed {
        logic signed [31:0] src_center_x;
        logic signed [31:0] src_center_y;
        logic [30:0]        src_half_x;
        logic [30:0]        src_half_y;
        logic signed [15:0] src_cos;
        logic signed [15:0] src_sin;
        logic signed [31:0] dst_center_x;
        logic signed [31:0] dst_center_y;
        logic [30:0]        dst_half_x;
        logic [30:0]        dst_half_y;
        logic signed [15:0] dst_cos;
        logic signed [15:0] dst_sin;
    } pair_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
    } result_t;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        hx;
        logic [30:0]        hy;
        logic signed [15:0] c;
        logic signed [15:0] s;
    } box_t;

    // clamp a 36 bit sum into 32 bit signed
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111)
            r = v[31:0];
        else if (v[35])
            r = 32'sh8000_0000;
        else
            r = 32'sh7fff_ffff;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/b2pc_corner.sv -----
// three stage corner unit: rotated half extents, rounding, saturated corners
// depends on b2pc_pkg
`default_nettype none

module b2pc_corner (
    input  wire logic               clk,
    input  wire logic [2:0]         en,
    input  wire b2pc_pkg::box_t     box,
    output logic signed [31:0]      lo_x,
    output logic signed [31:0]      lo_y,
    output logic signed [31:0]      hi_x,
    output logic signed [31:0]      hi_y
);

    logic signed [47:0] p_chx_reg, p_shy_reg, p_shx_reg, p_chy_reg;
    logic signed [31:0] cx1_reg, cy1_reg, cx2_reg, cy2_reg;
    logic signed [48:0] sum_x, sum_y;
    logic signed [34:0] ox_reg, oy_reg, ox_next, oy_next;
    logic signed [35:0] lx, ly, hx, hy;
    logic signed [31:0] lo_x_reg, lo_y_reg, hi_x_reg, hi_y_reg;

    // stage 1: the four products
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_chx_reg <= 48'($signed(box.c) * $signed({1'b0, box.hx}));
            p_shy_reg <= 48'($signed(box.s) * $signed({1'b0, box.hy}));
            p_shx_reg <= 48'($signed(box.s) * $signed({1'b0, box.hx}));
            p_chy_reg <= 48'($signed(box.c) * $signed({1'b0, box.hy}));
            cx1_reg   <= box.cx;
            cy1_reg   <= box.cy;
        end
    end

    // stage 2: offsets rounded half up to q16.16
    assign sum_x = $signed({p_chx_reg[47], p_chx_reg}) - $signed({p_shy_reg[47], p_shy_reg})
                 + 49'(b2pc_pkg::RndQ14);
    assign sum_y = $signed({p_shx_reg[47], p_shx_reg}) + $signed({p_chy_reg[47], p_chy_reg})
                 + 49'(b2pc_pkg::RndQ14);
    assign ox_next = sum_x[48:14];
    assign oy_next = sum_y[48:14];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ox_reg  <= ox_next;
            oy_reg  <= oy_next;
            cx2_reg <= cx1_reg;
            cy2_reg <= cy1_reg;
        end
    end

    // stage 3: saturated corners
    assign lx = $signed({{4{cx2_reg[31]}}, cx2_reg}) - $signed({ox_reg[34], ox_reg});
    assign ly = $signed({{4{cy2_reg[31]}}, cy2_reg}) - $signed({oy_reg[34], oy_reg});
    assign hx = $signed({{4{cx2_reg[31]}}, cx2_reg}) + $signed({ox_reg[34], ox_reg});
    assign hy = $signed({{4{cy2_reg[31]}}, cy2_reg}) + $signed({oy_reg[34], oy_reg});

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            lo_x_reg <= b2pc_pkg::sat32(lx);
            lo_y_reg <= b2pc_pkg::sat32(ly);
            hi_x_reg <= b2pc_pkg::sat32(hx);
            hi_y_reg <= b2pc_pkg::sat32(hy);
        end
    end

    assign lo_x = lo_x_reg;
    assign lo_y = lo_y_reg;
    assign hi_x = hi_x_reg;
    assign hi_y = hi_y_reg;

endmodule

`default_nettype wire

// ----- rtl/b2pc_axis.sv -----
// four stage separating axis check for one candidate axis
// no package dependencies
`default_nettype none

module b2pc_axis (
    input  wire logic               clk,
    input  wire logic [3:0]         en,
    input  wire logic signed [16:0] ax,
    input  wire logic signed [16:0] ay,
    input  wire logic [30:0]        half,
    input  wire logic signed [15:0] oc,
    input  wire logic signed [15:0] os,
    input  wire logic [30:0]        ohx,
    input  wire logic [30:0]        ohy,
    input  wire logic signed [32:0] dx,
    input  wire logic signed [32:0] dy,
    output logic                    ok
);

    logic signed [32:0] m_ac_reg, m_as_reg, m_xs_reg, m_yc_reg;
    logic signed [32:0] dx1_reg, dy1_reg;
    logic signed [16:0] ax1_reg, ay1_reg;
    logic [30:0]        half1_reg, half2_reg, half3_reg;
    logic [30:0]        ohx1_reg, ohy1_reg, ohx2_reg, ohy2_reg;
    logic signed [33:0] d1, d2;
    logic signed [19:0] r1, r2;
    logic [19:0]        px_reg, py_reg;
    logic signed [49:0] cxp_reg, cyp_reg;
    logic signed [50:0] csum;
    logic [50:0]        ctr_reg, ex1_reg, ex2_reg;
    logic [52:0]        ext;
    logic               ok_reg;

    // stage 1: axis dot products
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            m_ac_reg  <= 33'(ax * oc);
            m_as_reg  <= 33'(ay * os);
            m_xs_reg  <= 33'(ax * os);
            m_yc_reg  <= 33'(ay * oc);
            dx1_reg   <= dx;
            dy1_reg   <= dy;
            ax1_reg   <= ax;
            ay1_reg   <= ay;
            half1_reg <= half;
            ohx1_reg  <= ohx;
            ohy1_reg  <= ohy;
        end
    end

    // stage 2: rounded absolute projections, center line products
    assign d1 = $signed({m_ac_reg[32], m_ac_reg}) + $signed({m_as_reg[32], m_as_reg})
              + 34'sd8192;
    assign d2 = $signed({m_yc_reg[32], m_yc_reg}) - $signed({m_xs_reg[32], m_xs_reg})
              + 34'sd8192;
    assign r1 = d1[33:14];
    assign r2 = d2[33:14];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            px_reg    <= r1[19] ? 20'(-r1) : 20'(r1);
            py_reg    <= r2[19] ? 20'(-r2) : 20'(r2);
            cxp_reg   <= 50'(dx1_reg * ax1_reg);
            cyp_reg   <= 50'(dy1_reg * ay1_reg);
            half2_reg <= half1_reg;
            ohx2_reg  <= ohx1_reg;
            ohy2_reg  <= ohy1_reg;
        end
    end

    // stage 3: center distance, projected extents
    assign csum = $signed({cxp_reg[49], cxp_reg}) + $signed({cyp_reg[49], cyp_reg});

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            ctr_reg   <= csum[50] ? 51'(-csum) : 51'(csum);
            ex1_reg   <= 51'(px_reg * ohx2_reg);
            ex2_reg   <= 51'(py_reg * ohy2_reg);
            half3_reg <= half2_reg;
        end
    end

    // stage 4: strict compare
    assign ext = {8'b0, half3_reg, 14'b0} + {2'b0, ex1_reg} + {2'b0, ex2_reg};

    always_ff @(posedge clk)
    begin
        if (en[3])
            ok_reg <= ext > {2'b0, ctr_reg};
    end

    assign ok = ok_reg;

endmodule

`default_nettype wire

// ----- rtl/box2d_pair_collision.sv -----
// box pair collision: five stage pipeline from accept to result
// throughput one item per cycle, stall backs up stage by stage and fills bubbles
// rate set by every stage taking a new item each cycle unless the result side stalls
// reset clears only the stage valid bits; the data registers are not reset
// depends on b2pc_pkg, b2pc_corner, b2pc_axis and the assertion header
`default_nettype none
`include "box2d_pair_collision_defines.svh"

module box2d_pair_collision (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pair_valid,
    output logic                    pair_stall,
    input  wire b2pc_pkg::pair_t    pair,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output b2pc_pkg::result_t       result
);

    // stage valid bits and per stage load enables
    logic [5:1] v_reg, v_next;
    logic [5:1] ld;

    b2pc_pkg::box_t     box_a, box_b;
    logic signed [32:0] dx, dy;
    logic               unrot;
    logic               unrot1_reg, unrot2_reg, unrot3_reg, unrot4_reg;

    logic signed [31:0] alo_x, alo_y, ahi_x, ahi_y;
    logic signed [31:0] blo_x, blo_y, bhi_x, bhi_y;
    logic [3:0]         ok;

    logic               aabb4_reg;
    logic signed [31:0] lox4_reg, loy4_reg, hix4_reg, hiy4_reg;
    logic signed [32:0] sum_x, sum_y;
    logic               hit;
    b2pc_pkg::result_t  result_reg, result_next;

    // a stage loads when empty or when the next one moves on
    always_comb
    begin
        ld[5] = !v_reg[5] || !result_stall;
        ld[4] = !v_reg[4] || ld[5];
        ld[3] = !v_reg[3] || ld[4];
        ld[2] = !v_reg[2] || ld[3];
        ld[1] = !v_reg[1] || ld[2];
    end

    always_comb
    begin
        v_next[1] = ld[1] ? pair_valid : v_reg[1];
        v_next[2] = ld[2] ? v_reg[1]   : v_reg[2];
        v_next[3] = ld[3] ? v_reg[2]   : v_reg[3];
        v_next[4] = ld[4] ? v_reg[3]   : v_reg[4];
        v_next[5] = ld[5] ? v_reg[4]   : v_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign pair_stall   = !ld[1];
    assign result_valid = v_reg[5];

    // unpack the two boxes
    always_comb
    begin
        box_a.cx = pair.src_center_x;
        box_a.cy = pair.src_center_y;
        box_a.hx = pair.src_half_x;
        box_a.hy = pair.src_half_y;
        box_a.c  = pair.src_cos;
        box_a.s  = pair.src_sin;
        box_b.cx = pair.dst_center_x;
        box_b.cy = pair.dst_center_y;
        box_b.hx = pair.dst_half_x;
        box_b.hy = pair.dst_half_y;
        box_b.c  = pair.dst_cos;
        box_b.s  = pair.dst_sin;
    end

    // center line at 33 bits, no saturation
    assign dx = $signed({box_a.cx[31], box_a.cx}) - $signed({box_b.cx[31], box_b.cx});
    assign dy = $signed({box_a.cy[31], box_a.cy}) - $signed({box_b.cy[31], box_b.cy});

    // axis aligned path only for exact identity rotation on both boxes
    assign unrot = box_a.c == b2pc_pkg::OneQ14 && box_a.s == 16'sd0
                && box_b.c == b2pc_pkg::OneQ14 && box_b.s == 16'sd0;

    always_ff @(posedge clk)
    begin
        if (ld[1])
            unrot1_reg <= unrot;
        if (ld[2])
            unrot2_reg <= unrot1_reg;
        if (ld[3])
            unrot3_reg <= unrot2_reg;
    end

    // corners, ready at the end of stage 3
    b2pc_corner u_corner_a (
        .clk  (clk),
        .en   (ld[3:1]),
        .box  (box_a),
        .lo_x (alo_x),
        .lo_y (alo_y),
        .hi_x (ahi_x),
        .hi_y (ahi_y)
    );

    b2pc_corner u_corner_b (
        .clk  (clk),
        .en   (ld[3:1]),
        .box  (box_b),
        .lo_x (blo_x),
        .lo_y (blo_y),
        .hi_x (bhi_x),
        .hi_y (bhi_y)
    );

    // four candidate axes: source x and y against destination, then the reverse
    b2pc_axis u_axis_ax (
        .clk  (clk),
        .en   (ld[4:1]),
        .ax   ({box_a.c[15], box_a.c}),
        .ay   ({box_a.s[15], box_a.s}),
        .half (box_a.hx),
        .oc   (box_b.c),
        .os   (box_b.s),
        .ohx  (box_b.hx),
        .ohy  (box_b.hy),
        .dx   (dx),
        .dy   (dy),
        .ok   (ok[0])
    );

    b2pc_axis u_axis_ay (
        .clk  (clk),
        .en   (ld[4:1]),
        .ax   (17'(-$signed({box_a.s[15], box_a.s}))),
        .ay   ({box_a.c[15], box_a.c}),
        .half (box_a.hy),
        .oc   (box_b.c),
        .os   (box_b.s),
        .ohx  (box_b.hx),
        .ohy  (box_b.hy),
        .dx   (dx),
        .dy   (dy),
        .ok   (ok[1])
    );

    b2pc_axis u_axis_bx (
        .clk  (clk),
        .en   (ld[4:1]),
        .ax   ({box_b.c[15], box_b.c}),
        .ay   ({box_b.s[15], box_b.s}),
        .half (box_b.hx),
        .oc   (box_a.c),
        .os   (box_a.s),
        .ohx  (box_a.hx),
        .ohy  (box_a.hy),
        .dx   (dx),
        .dy   (dy),
        .ok   (ok[2])
    );

    b2pc_axis u_axis_by (
        .clk  (clk),
        .en   (ld[4:1]),
        .ax   (17'(-$signed({box_b.s[15], box_b.s}))),
        .ay   ({box_b.c[15], box_b.c}),
        .half (box_b.hy),
        .oc   (box_a.c),
        .os   (box_a.s),
        .ohx  (box_a.hx),
        .ohy  (box_a.hy),
        .dx   (dx),
        .dy   (dy),
        .ok   (ok[3])
    );

    // stage 4: inclusive aabb overlap, componentwise intersection
    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            aabb4_reg  <= !(alo_x > bhi_x || blo_x > ahi_x ||
                            alo_y > bhi_y || blo_y > ahi_y);
            lox4_reg   <= (alo_x > blo_x) ? alo_x : blo_x;
            loy4_reg   <= (alo_y > blo_y) ? alo_y : blo_y;
            hix4_reg   <= (ahi_x < bhi_x) ? ahi_x : bhi_x;
            hiy4_reg   <= (ahi_y < bhi_y) ? ahi_y : bhi_y;
            unrot4_reg <= unrot3_reg;
        end
    end

    // stage 5: pick the test, midpoint rounded toward minus infinity
    assign sum_x = $signed({lox4_reg[31], lox4_reg}) + $signed({hix4_reg[31], hix4_reg});
    assign sum_y = $signed({loy4_reg[31], loy4_reg}) + $signed({hiy4_reg[31], hiy4_reg});
    assign hit   = unrot4_reg ? aabb4_reg : &ok;

    always_comb
    begin
        result_next.hit   = hit;
        result_next.hit_x = hit ? sum_x[32:1] : 32'sd0;
        result_next.hit_y = hit ? sum_y[32:1] : 32'sd0;
    end

    always_ff @(posedge clk)
    begin
        if (ld[5])
            result_reg <= result_next;
    end

    assign result = result_reg;

    `B2PC_ASSERT_IMPLY(a_miss_zero, result_valid && !result.hit,
        result.hit_x == 32'sd0 && result.hit_y == 32'sd0, "miss with nonzero hit point")
    `B2PC_ASSERT_IMPLY(a_stall_full, pair_stall, &v_reg, "input stalled with a bubble in the pipe")
    `B2PC_ASSERT_NEXT(a_hold_s1, v_reg[1] && !ld[2], v_reg[1], "stage 1 item lost while blocked")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for box2d_pair_collision, the rotated box pair hit test
// depends on b2pc_pkg and the block's rtl; holds its own hit predictor and scoreboard
`timescale 1ns / 100ps

module tb_top;

    localparam int IdleLimit = 5000;   // cycles with no accept or result before giving up
    localparam int HoldOff   = 80;     // long receiver hold-off, in cycles
    localparam int NumRandom = 1530;

    // one box widened to 64 bits for exact arithmetic
    typedef struct {
        longint cx, cy, hx, hy, c, s;
    } geom_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              pair_valid;
    logic              pair_stall;
    b2pc_pkg::pair_t   pair;
    logic              result_valid;
    logic              result_stall;
    b2pc_pkg::result_t result;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    box2d_pair_collision DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_stall   (pair_stall),
        .pair         (pair),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // ---------------------------------------------------------------
    // hit predictor
    // ---------------------------------------------------------------

    function automatic geom_t widen(b2pc_pkg::box_t b);
        geom_t g;
        g.cx = longint'($signed(b.cx));
        g.cy = longint'($signed(b.cy));
        g.hx = longint'({1'b0, b.hx});
        g.hy = longint'({1'b0, b.hy});
        g.c  = longint'($signed(b.c));
        g.s  = longint'($signed(b.s));
        return g;
    endfunction

    // Q.28 to Q.14 with half rounding up
    function automatic longint round_q14(longint v);
        return (v + 64'sd8192) >>> 14;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // corners as lo x, lo y, hi x, hi y; each saturated
    function automatic void box_corners(geom_t g, output longint k[4]);
        longint ox, oy;
        ox = round_q14(g.c * g.hx - g.s * g.hy);
        oy = round_q14(g.s * g.hx + g.c * g.hy);
        k[0] = clamp32(g.cx - ox);
        k[1] = clamp32(g.cy - oy);
        k[2] = clamp32(g.cx + ox);
        k[3] = clamp32(g.cy + oy);
    endfunction

    // axis (ax,ay) fails to separate when extent beats the center distance strictly
    function automatic bit axis_overlaps(longint dx, longint dy, longint ax, longint ay,
                                         longint half, geom_t o);
        longint ctr, px, py, ext;
        ctr = mag(dx * ax + dy * ay);
        px  = mag(round_q14(ax * o.c + ay * o.s));
        py  = mag(round_q14(-ax * o.s + ay * o.c));
        ext = half * 16384 + px * o.hx + py * o.hy;
        return ext > ctr;
    endfunction

    function automatic bit is_flat(geom_t g);
        return g.c == 16384 && g.s == 0;
    endfunction

    function automatic b2pc_pkg::result_t predict_hit(b2pc_pkg::pair_t p);
        geom_t             a, b;
        longint            ka[4], kb[4];
        longint            dx, dy, lo, hi;
        bit                h;
        b2pc_pkg::result_t r;
        a = widen(p[315:158]);
        b = widen(p[157:0]);
        box_corners(a, ka);
        box_corners(b, kb);
        if (is_flat(a) && is_flat(b))
        begin
            // touching edges count as a hit
            h = !(ka[0] > kb[2] || kb[0] > ka[2] || ka[1] > kb[3] || kb[1] > ka[3]);
        end
        else
        begin
            dx = a.cx - b.cx;
            dy = a.cy - b.cy;
            h = axis_overlaps(dx, dy, a.c, a.s, a.hx, b) &&
                axis_overlaps(dx, dy, -a.s, a.c, a.hy, b) &&
                axis_overlaps(dx, dy, b.c, b.s, b.hx, a) &&
                axis_overlaps(dx, dy, -b.s, b.c, b.hy, a);
        end
        r = '0;
        r.hit = h;
        if (h)
        begin
            lo = (ka[0] > kb[0]) ? ka[0] : kb[0];
            hi = (ka[2] < kb[2]) ? ka[2] : kb[2];
            r.hit_x = 32'((lo + hi) >>> 1);
            lo = (ka[1] > kb[1]) ? ka[1] : kb[1];
            hi = (ka[3] < kb[3]) ? ka[3] : kb[3];
            r.hit_y = 32'((lo + hi) >>> 1);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // scoreboard
    // ---------------------------------------------------------------

    class hit_board;
        b2pc_pkg::result_t want_q[$];
        int                errors;
        int                accepted;
        int                checked;
        int                hits;
        int                flat_pairs;

        function void note_pair(b2pc_pkg::pair_t p);
            b2pc_pkg::result_t r;
            r = predict_hit(p);
            want_q.push_back(r);
            accepted++;
            if (r.hit)
                hits++;
            if (is_flat(widen(p[315:158])) && is_flat(widen(p[157:0])))
                flat_pairs++;
        endfunction

        function void check_result(b2pc_pkg::result_t got);
            b2pc_pkg::result_t want;
            if (want_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result with nothing pending: hit=%0b x=%0d y=%0d",
                             got.hit, got.hit_x, got.hit_y);
                return;
            end
            want = want_q.pop_front();
            checked++;
            if (got.hit !== want.hit || got.hit_x !== want.hit_x ||
                got.hit_y !== want.hit_y)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch on result %0d: want hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                             checked, want.hit, want.hit_x, want.hit_y,
                             got.hit, got.hit_x, got.hit_y);
            end
        endfunction
    endclass

    hit_board board = new();

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    int idle_pct  = 29;   // sender gap chance, percent
    int stall_pct = 29;   // receiver stall chance, percent
    int hold_req  = 0;    // bumped by the main flow to ask for a long hold-off
    int idle_cycles = 0;

    // a box near (bx,by); wild boxes take every bit at random
    function automatic b2pc_pkg::box_t rand_box(bit wild, logic signed [31:0] bx,
                                                logic signed [31:0] by, bit flat);
        b2pc_pkg::box_t b;
        int             pick;
        if (wild)
        begin
            b.cx = $urandom;
            b.cy = $urandom;
            b.hx = 31'($urandom);
            b.hy = 31'($urandom);
            b.c  = 16'($urandom);
            b.s  = 16'($urandom);
            return b;
        end
        b.cx = bx + ($urandom_range(0, 2 ** 21) - 2 ** 20);
        b.cy = by + ($urandom_range(0, 2 ** 21) - 2 ** 20);
        if ($urandom_range(0, 19) == 0)
        begin
            b.hx = 31'($urandom);
            b.hy = 31'($urandom);
        end
        else
        begin
            b.hx = 31'($urandom_range(0, 2 ** 20));
            b.hy = 31'($urandom_range(0, 2 ** 20));
        end
        pick = flat ? 0 : $urandom_range(0, 9);
        case (pick)
            0: begin b.c = b2pc_pkg::OneQ14;  b.s = 16'sd0;            end
            1: begin b.c = 16'sd0;            b.s = b2pc_pkg::OneQ14;  end
            2: begin b.c = -b2pc_pkg::OneQ14; b.s = 16'sd0;            end
            3: begin b.c = 16'sd0;            b.s = -b2pc_pkg::OneQ14; end
            4: begin b.c = 16'sd11585; b.s = 16'sd11585; end
            5: begin b.c = 16'sd11585; b.s = -16'sd11585; end
            6: begin b.c = 16'sd14189; b.s = 16'sd8192;  end
            7: begin b.c = -16'sd8192; b.s = 16'sd14189; end
            default:
            begin
                b.c = 16'($urandom_range(0, 32768) - 16384);
                b.s = 16'($urandom_range(0, 32768) - 16384);
            end
        endcase
        return b;
    endfunction

    function automatic b2pc_pkg::pair_t rand_pair();
        logic signed [31:0] bx, by;
        int  m;
        bit  flat;
        m = $urandom_range(0, 99);
        if (m < 6)
            return {rand_box(1'b1, 0, 0, 1'b0), rand_box(1'b1, 0, 0, 1'b0)};
        if (m < 16)
        begin
            bx = $urandom;
            by = $urandom;
        end
        else
        begin
            bx = $urandom_range(0, 2 ** 24) - 2 ** 23;
            by = $urandom_range(0, 2 ** 24) - 2 ** 23;
        end
        flat = ($urandom_range(0, 99) < 40);
        return {rand_box(1'b0, bx, by, flat), rand_box(1'b0, bx, by, flat)};
    endfunction

    function automatic b2pc_pkg::box_t mk_box(int cx, int cy, int hx, int hy, int c, int s);
        b2pc_pkg::box_t b;
        b.cx = cx;
        b.cy = cy;
        b.hx = 31'(hx);
        b.hy = 31'(hy);
        b.c  = 16'(c);
        b.s  = 16'(s);
        return b;
    endfunction

    // offer one item, with random gaps ahead of it, and wait until taken
    task automatic send_pair(b2pc_pkg::pair_t p);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            pair_valid <= 1'b0;
            @(posedge clk);
        end
        pair_valid <= 1'b1;
        pair       <= p;
        @(posedge clk);
        while (pair_stall)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // receiver stalls, with a long hold-off on request
    // ---------------------------------------------------------------
    initial
    begin : receiver
        int seen;
        int hold;
        seen = 0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != seen)
            begin
                seen = hold_req;
                hold = HoldOff;
            end
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                hold--;
            end
            else
                result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // monitors and watchdog
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pair_valid && !pair_stall)
                board.note_pair(pair);
            if (result_valid && !result_stall)
                board.check_result(result);
            if ((pair_valid && !pair_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit)
            begin
                $display("watchdog: no progress for %0d cycles", IdleLimit);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // main flow
    // ---------------------------------------------------------------
    initial
    begin : main_flow
        b2pc_pkg::pair_t dir_q[$];
        int              i;
        int              wait_cnt;

        rst_n        = 1'b0;
        pair_valid   = 1'b0;
        pair         = '0;
        result_stall = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zeros, extremes, touching and strict edges, odd rotations
        dir_q.push_back('0);
        dir_q.push_back('1);
        dir_q.push_back({mk_box(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                16384, 0),
                         mk_box(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                16384, 0)});
        dir_q.push_back({mk_box(32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 16384, 0),
                         mk_box(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 16384, 0)});
        // flat boxes touching on x, then one lsb apart, then touching on y
        dir_q.push_back({mk_box(0, 0, 65536, 65536, 16384, 0),
                         mk_box(131072, 0, 65536, 65536, 16384, 0)});
        dir_q.push_back({mk_box(0, 0, 65536, 65536, 16384, 0),
                         mk_box(131073, 0, 65536, 65536, 16384, 0)});
        dir_q.push_back({mk_box(0, -5, 65536, 65536, 16384, 0),
                         mk_box(0, 131067, 65536, 65536, 16384, 0)});
        // rotated boxes exactly touching fail the strict test, one lsb closer they hit
        dir_q.push_back({mk_box(0, 0, 65536, 65536, 0, 16384),
                         mk_box(131072, 0, 65536, 65536, 16384, 0)});
        dir_q.push_back({mk_box(0, 0, 65536, 65536, 0, 16384),
                         mk_box(131071, 0, 65536, 65536, 16384, 0)});
        // crossed corners from a half turn
        dir_q.push_back({mk_box(1000, 2000, 300000, 70000, -16384, 0),
                         mk_box(-5000, 9000, 40000, 500000, 16384, 0)});
        // non-unit rotation values, in range and out of it
        dir_q.push_back({mk_box(0, 0, 65536, 65536, 32767, -32768),
                         mk_box(100, 100, 65536, 65536, 16384, 0)});
        dir_q.push_back({mk_box(0, 0, 65536, 65536, -32768, 32767),
                         mk_box(9000, -9000, 1, 1, 0, 0)});
        dir_q.push_back({mk_box(0, 0, 65536, 65536, 16383, 0),
                         mk_box(0, 0, 65536, 65536, 16384, 0)});
        dir_q.push_back({mk_box(0, 0, 0, 0, 16384, 1),
                         mk_box(0, 0, 0, 0, 16384, 0)});
        // diagonal boxes, corner saturation through rotation
        dir_q.push_back({mk_box(32'h7fff0000, 0, 32'h7fffffff, 32'h7fffffff, 11585, 11585),
                         mk_box(32'h7fff0000, 0, 32'h7fffffff, 32'h7fffffff, -11585,
                                11585)});
        dir_q.push_back({mk_box(50000, -30000, 90000, 20000, 11585, -11585),
                         mk_box(-20000, 10000, 60000, 60000, 14189, 8192)});
        foreach (dir_q[k])
            send_pair(dir_q[k]);

        // random: a clean stretch with no gaps and a long hold-off that
        // backs the pipe up into the input, then mixed idling
        for (i = 0; i < NumRandom; i++)
        begin
            if (i == 100)
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            if (i == 150)
                hold_req = hold_req + 1;
            if (i == 400)
            begin
                idle_pct  = 29;
                stall_pct = 29;
            end
            send_pair(rand_pair());
        end
        pair_valid <= 1'b0;

        wait_cnt = 0;
        while (board.want_q.size() != 0 && wait_cnt < IdleLimit)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (20) @(posedge clk);

        if (board.want_q.size() != 0)
        begin
            board.errors += board.want_q.size();
            $display("%0d results never arrived", board.want_q.size());
        end
        $display("box pairs sent %0d, results checked %0d, hits %0d, both unrotated %0d",
                 board.accepted, board.checked, board.hits, board.flat_pairs);
        $display("mismatches %0d", board.errors);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- box2d_pair_collision.f -----
+incdir+rtl
rtl/b2pc_pkg.sv
rtl/b2pc_corner.sv
rtl/b2pc_axis.sv
rtl/box2d_pair_collision.sv
tb/tb_top.sv
